>>> hdl/cear_pkg.sv
// ---------------------------------------------------------------------------
// cear_pkg
// Shared constants, types and helpers for the cell edge aspect ratio block.
// ---------------------------------------------------------------------------
package cear_pkg;

   // default coordinate width and ratio fraction bits
   localparam int COORD_WIDTH     = 24;
   localparam int RATIO_FRAC_BITS = 16;

   // edge length scale: len = floor(sqrt(sum_sq * 2^LEN_SCALE))
   localparam int LEN_SCALE       = 16;

   // result word
   localparam int RESULT_WIDTH    = 32;

   // queue between front and back
   localparam int QUEUE_DEPTH     = 4;

   localparam int NUM_EDGES       = 3;
   localparam int NUM_AXES        = 3;
   localparam int NUM_PAIRS       = 6;

   typedef logic [1:0] edge_idx_type;

   // numerator and denominator edge of each ordered pair
   localparam edge_idx_type PAIR_NUM [NUM_PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam edge_idx_type PAIR_DEN [NUM_PAIRS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

   // bits of an edge length for a given coordinate width
   function automatic int len_width(int cw);
      int sum_w;
      sum_w = 2 * (cw + 1) + 2;
      return (sum_w + LEN_SCALE + 1) >> 1;
   endfunction

endpackage

>>> hdl/cear_if.sv
// ---------------------------------------------------------------------------
// cear_req_if / cear_rsp_if
// Valid/ready channels for cells in and ratios out.
// ---------------------------------------------------------------------------
interface cear_req_if #(
   parameter int COORD_WIDTH = cear_pkg::COORD_WIDTH
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] base_x;
   logic signed [COORD_WIDTH-1:0] base_y;
   logic signed [COORD_WIDTH-1:0] base_z;
   logic signed [COORD_WIDTH-1:0] inext_x;
   logic signed [COORD_WIDTH-1:0] inext_y;
   logic signed [COORD_WIDTH-1:0] inext_z;
   logic signed [COORD_WIDTH-1:0] jnext_x;
   logic signed [COORD_WIDTH-1:0] jnext_y;
   logic signed [COORD_WIDTH-1:0] jnext_z;
   logic signed [COORD_WIDTH-1:0] knext_x;
   logic signed [COORD_WIDTH-1:0] knext_y;
   logic signed [COORD_WIDTH-1:0] knext_z;

   modport source (
      output valid, base_x, base_y, base_z, inext_x, inext_y, inext_z,
             jnext_x, jnext_y, jnext_z, knext_x, knext_y, knext_z,
      input  ready
   );
   modport sink (
      input  valid, base_x, base_y, base_z, inext_x, inext_y, inext_z,
             jnext_x, jnext_y, jnext_z, knext_x, knext_y, knext_z,
      output ready
   );
endinterface

interface cear_rsp_if ();
   logic                              valid;
   logic                              ready;
   logic [cear_pkg::RESULT_WIDTH-1:0] max_ratio;
   logic                              saturated;

   modport source (output valid, max_ratio, saturated, input ready);
   modport sink (input valid, max_ratio, saturated, output ready);
endinterface

>>> hdl/cear_front.sv
// ---------------------------------------------------------------------------
// cear_front
// Edge vectors, squared lengths and a bit-per-stage square root pipeline.
// ---------------------------------------------------------------------------
module cear_front #(
   parameter int COORD_WIDTH = cear_pkg::COORD_WIDTH,
   parameter int LEN_WIDTH   = cear_pkg::len_width(cear_pkg::COORD_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   cear_req_if.sink               req,
   output logic                   len_valid,
   input  logic                   len_ready,
   output logic [3*LEN_WIDTH-1:0] len_data
);
   import cear_pkg::*;

   localparam int DW   = COORD_WIDTH + 1;
   localparam int SW   = 2 * DW + 2;
   localparam int RW   = LEN_WIDTH;
   localparam int XW   = 2 * RW;
   localparam int RMW  = RW + 2;
   localparam int NSTG = 3 + RW;

   logic                          adv;
   logic [NSTG-1:0]               vld_ff;
   logic signed [COORD_WIDTH-1:0] corner [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] nbr [NUM_EDGES][NUM_AXES];

   logic [DW-1:0]   mag_ff [NUM_EDGES][NUM_AXES];
   logic [DW-1:0]   mag_in [NUM_EDGES][NUM_AXES];
   logic [2*DW-1:0] sq_ff  [NUM_EDGES][NUM_AXES];
   logic [2*DW-1:0] sq_in  [NUM_EDGES][NUM_AXES];
   logic [SW-1:0]   sum_ff [NUM_EDGES];
   logic [SW-1:0]   sum_in [NUM_EDGES];
   logic [XW-1:0]   rad_ff  [NUM_EDGES][RW];
   logic [XW-1:0]   rad_in  [NUM_EDGES][RW];
   logic [RMW-1:0]  rem_ff  [NUM_EDGES][RW];
   logic [RMW-1:0]  rem_in  [NUM_EDGES][RW];
   logic [RW-1:0]   root_ff [NUM_EDGES][RW];
   logic [RW-1:0]   root_in [NUM_EDGES][RW];

   // whole pipeline moves unless the last stage is held
   assign adv       = !vld_ff[NSTG-1] || len_ready;
   assign req.ready = adv;
   assign len_valid = vld_ff[NSTG-1];
   assign len_data  = {root_ff[2][RW-1], root_ff[1][RW-1], root_ff[0][RW-1]};

   // coordinate unpacking
   assign corner[0] = req.base_x;
   assign corner[1] = req.base_y;
   assign corner[2] = req.base_z;
   assign nbr[0][0] = req.inext_x;
   assign nbr[0][1] = req.inext_y;
   assign nbr[0][2] = req.inext_z;
   assign nbr[1][0] = req.jnext_x;
   assign nbr[1][1] = req.jnext_y;
   assign nbr[1][2] = req.jnext_z;
   assign nbr[2][0] = req.knext_x;
   assign nbr[2][1] = req.knext_y;
   assign nbr[2][2] = req.knext_z;

   // edge component magnitudes
   always_comb begin
      logic [DW-1:0] dif;
      for (int e = 0; e < NUM_EDGES; e++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            dif = {nbr[e][a][COORD_WIDTH-1], nbr[e][a]} -
                  {corner[a][COORD_WIDTH-1], corner[a]};
            mag_in[e][a] = dif[DW-1] ? DW'(-dif) : dif;
         end
      end
   end

   // squares and sums of squares
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            sq_in[e][a] = {{DW{1'b0}}, mag_ff[e][a]} * {{DW{1'b0}}, mag_ff[e][a]};
         end
         sum_in[e] = SW'(sq_ff[e][0]) + SW'(sq_ff[e][1]) + SW'(sq_ff[e][2]);
      end
   end

   // square root, one result bit per stage
   always_comb begin
      logic [XW-1:0]  prad;
      logic [RMW-1:0] prem;
      logic [RW-1:0]  proot;
      logic [RMW+1:0] cat;
      logic [RMW+1:0] trl;
      for (int e = 0; e < NUM_EDGES; e++) begin
         for (int s = 0; s < RW; s++) begin
            if (s == 0) begin
               prad  = XW'({sum_ff[e], {LEN_SCALE{1'b0}}});
               prem  = '0;
               proot = '0;
            end else begin
               prad  = rad_ff[e][s-1];
               prem  = rem_ff[e][s-1];
               proot = root_ff[e][s-1];
            end
            cat = {prem, prad[2*(RW-1-s) +: 2]};
            trl = (RMW+2)'({proot, 2'b01});
            rad_in[e][s] = prad;
            if (cat >= trl) begin
               rem_in[e][s]  = RMW'(cat - trl);
               root_in[e][s] = {proot[RW-2:0], 1'b1};
            end else begin
               rem_in[e][s]  = RMW'(cat);
               root_in[e][s] = {proot[RW-2:0], 1'b0};
            end
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req.valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff  <= mag_in;
         sq_ff   <= sq_in;
         sum_ff  <= sum_in;
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

endmodule

>>> hdl/cear_fifo.sv
// ---------------------------------------------------------------------------
// cear_fifo
// Short queue of edge length triples between front and back.
// ---------------------------------------------------------------------------
module cear_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cear_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import cear_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/cear_back.sv
// ---------------------------------------------------------------------------
// cear_back
// Six pipelined restoring dividers, clamp, max tree and output register.
// ---------------------------------------------------------------------------
module cear_back #(
   parameter int LEN_WIDTH       = cear_pkg::len_width(cear_pkg::COORD_WIDTH),
   parameter int RATIO_FRAC_BITS = cear_pkg::RATIO_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   len_valid,
   output logic                   len_ready,
   input  logic [3*LEN_WIDTH-1:0] len_data,
   cear_rsp_if.source             rsp
);
   import cear_pkg::*;

   localparam int RW   = LEN_WIDTH;
   localparam int NQ   = RW + RATIO_FRAC_BITS;
   localparam int EXTW = (NQ > RESULT_WIDTH) ? NQ : RESULT_WIDTH + 1;
   localparam int NSTG = NQ + 1;

   logic            adv, out_load;
   logic [NSTG-1:0] vld_ff;
   logic [RW-1:0]   lens [NUM_EDGES];

   logic [RW-1:0] num_ff  [NUM_PAIRS][NQ];
   logic [RW-1:0] num_in  [NUM_PAIRS][NQ];
   logic [RW-1:0] den_ff  [NUM_PAIRS][NQ];
   logic [RW-1:0] den_in  [NUM_PAIRS][NQ];
   logic [RW-1:0] rem_ff  [NUM_PAIRS][NQ];
   logic [RW-1:0] rem_in  [NUM_PAIRS][NQ];
   logic [NQ-1:0] quot_ff [NUM_PAIRS][NQ];
   logic [NQ-1:0] quot_in [NUM_PAIRS][NQ];

   logic [RESULT_WIDTH-1:0] m1_ff [3];
   logic [RESULT_WIDTH-1:0] m1_in [3];
   logic                    msat_ff, msat_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   // output register takes a transfer when empty or drained
   assign out_load      = !rsp_valid_ff || rsp.ready;
   assign adv           = !vld_ff[NSTG-1] || out_load;
   assign len_ready     = adv;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.max_ratio = rsp_ratio_ff;
   assign rsp.saturated = rsp_sat_ff;

   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         lens[e] = len_data[e*RW +: RW];
      end
   end

   // long division, one quotient bit per stage
   always_comb begin
      logic [RW-1:0] pnum, pden, prem;
      logic [NQ-1:0] pq;
      logic [RW:0]   cat;
      logic          ge;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         for (int s = 0; s < NQ; s++) begin
            if (s == 0) begin
               pnum = lens[PAIR_NUM[p]];
               pden = lens[PAIR_DEN[p]];
               prem = '0;
               pq   = '0;
            end else begin
               pnum = num_ff[p][s-1];
               pden = den_ff[p][s-1];
               prem = rem_ff[p][s-1];
               pq   = quot_ff[p][s-1];
            end
            cat = {prem, pnum[RW-1]};
            ge  = (cat >= {1'b0, pden});
            rem_in[p][s]  = ge ? RW'(cat - {1'b0, pden}) : RW'(cat);
            num_in[p][s]  = {pnum[RW-2:0], 1'b0};
            den_in[p][s]  = pden;
            quot_in[p][s] = {pq[NQ-2:0], ge};
         end
      end
   end

   // clamp each quotient, first level of the max tree
   always_comb begin
      logic [EXTW-1:0]         ext;
      logic                    dz;
      logic                    psat [NUM_PAIRS];
      logic [RESULT_WIDTH-1:0] pval [NUM_PAIRS];
      for (int p = 0; p < NUM_PAIRS; p++) begin
         ext     = EXTW'(quot_ff[p][NQ-1]);
         dz      = (den_ff[p][NQ-1] == '0);
         psat[p] = !dz && (|ext[EXTW-1:RESULT_WIDTH]);
         if (dz) begin
            pval[p] = '0;
         end else if (psat[p]) begin
            pval[p] = '1;
         end else begin
            pval[p] = ext[RESULT_WIDTH-1:0];
         end
      end
      msat_in = psat[0] | psat[1] | psat[2] | psat[3] | psat[4] | psat[5];
      for (int g = 0; g < 3; g++) begin
         m1_in[g] = (pval[2*g] > pval[2*g+1]) ? pval[2*g] : pval[2*g+1];
      end
   end

   // final max into output register
   always_comb begin
      logic [RESULT_WIDTH-1:0] m01;
      m01          = (m1_ff[0] > m1_ff[1]) ? m1_ff[0] : m1_ff[1];
      rsp_valid_in = rsp_valid_ff;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (out_load) begin
         rsp_valid_in = vld_ff[NSTG-1];
         rsp_ratio_in = (m01 > m1_ff[2]) ? m01 : m1_ff[2];
         rsp_sat_in   = msat_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            vld_ff <= {vld_ff[NSTG-2:0], len_valid};
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_sat_ff   <= rsp_sat_in;
      if (adv) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         m1_ff   <= m1_in;
         msat_ff <= msat_in;
      end
   end

endmodule

>>> hdl/cell_edge_aspect_ratio_top.sv
// ---------------------------------------------------------------------------
// cell_edge_aspect_ratio_top
// Largest pairwise edge length quotient of one hexahedral grid cell.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one cell per transfer: the corner point and its neighbours
//   along i, j and k as signed coordinates. rsp_ch returns one transfer per
//   cell: max_ratio (unsigned, RATIO_FRAC_BITS fraction bits) and saturated.
//   Results come back in the order the cells went in.
// Throughput: one cell per clock cycle, sustained, as long as rsp_ch drains.
// Path: a cell passes the square root pipeline (one root bit per stage of
//   the edge length, which is 34 bits wide with 24-bit coordinates), the
//   queue, then the divider pipelines (one quotient bit per stage) and the
//   output register.
// Stall: when rsp_ch is not ready the back pipeline holds, the four-entry
//   queue fills, and then req_ch ready drops; no cell is lost or repeated.
// Reset: synchronous; clears all valid bits and the queue, no result is
//   pending afterwards and the block is ready on the next cycle.
// ---------------------------------------------------------------------------
module cell_edge_aspect_ratio_top #(
   parameter int COORD_WIDTH     = cear_pkg::COORD_WIDTH,
   parameter int RATIO_FRAC_BITS = cear_pkg::RATIO_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   cear_req_if.sink   req_ch,
   cear_rsp_if.source rsp_ch
);
   import cear_pkg::*;

   localparam int LEN_WIDTH = len_width(COORD_WIDTH);

   logic                   f_valid, f_ready;
   logic [3*LEN_WIDTH-1:0] f_data;
   logic                   b_valid, b_ready;
   logic [3*LEN_WIDTH-1:0] b_data;

   // edge lengths
   cear_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .LEN_WIDTH   (LEN_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .len_valid (f_valid),
      .len_ready (f_ready),
      .len_data  (f_data)
   );

   // decoupling queue
   cear_fifo #(
      .WIDTH (3 * LEN_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   // quotients and max
   cear_back #(
      .LEN_WIDTH       (LEN_WIDTH),
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .len_valid (b_valid),
      .len_ready (b_ready),
      .len_data  (b_data),
      .rsp       (rsp_ch)
   );

endmodule

>>> bench/tb_cell_edge_aspect_ratio_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cell_edge_aspect_ratio_top
// Self-checking bench for the cell edge aspect ratio block: directed corner
// cells then random cells, each predicted in the bench and compared in order.
// ---------------------------------------------------------------------------

// in-order store of predicted ratios and the comparison against results
class ratio_scoreboard;
   typedef struct packed {
      logic [31:0] max_ratio;
      logic        saturated;
   } ratio_type;

   ratio_type pending_q[$];
   int     error_count;
   int     checked_count;
   int     sat_count;
   int     zero_count;

   function new();
      error_count   = 0;
      checked_count = 0;
      sat_count     = 0;
      zero_count    = 0;
   endfunction

   // floor(sqrt(v)) by bit-serial search
   static function logic [63:0] int_sqrt(logic [127:0] v);
      logic [63:0]  root;
      logic [63:0]  cand;
      root = '0;
      for (int b = 47; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (128'(cand) * 128'(cand) <= v)
            root = cand;
      end
      return root;
   endfunction

   static function logic [63:0] edge_len(logic signed [23:0] p0[3],
                                         logic signed [23:0] p1[3]);
      logic signed [25:0] d;
      logic [127:0]       acc;
      acc = '0;
      for (int a = 0; a < 3; a++) begin
         d = 26'(p1[a]) - 26'(p0[a]);
         acc = acc + 128'(d) * 128'(d);
      end
      return int_sqrt(acc << 16);
   endfunction

   // predicted response for one cell
   function void note_cell(logic signed [23:0] pt[4][3]);
      logic [63:0] lens[3];
      logic [63:0] best;
      logic [63:0] ip;
      logic [63:0] q;
      logic [127:0] wide;
      ratio_type   r;
      best = '0;
      r.saturated = 1'b0;
      for (int e = 0; e < 3; e++)
         lens[e] = edge_len(pt[0], pt[e + 1]);
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++) begin
            if (a == b || lens[b] == 0)
               continue;
            ip = lens[a] / lens[b];
            if (ip >= 64'd65536) begin
               r.saturated = 1'b1;
               q = 64'hFFFF_FFFF;
            end else begin
               wide = (128'(lens[a]) << 16) / 128'(lens[b]);
               q = wide[63:0];
            end
            if (q > best)
               best = q;
         end
      r.max_ratio = best[31:0];
      pending_q.push_back(r);
   endfunction

   // compare one result transfer against the oldest prediction
   task check_result(logic [31:0] ratio, logic sat);
      ratio_type exp_r;
      checked_count++;
      if (pending_q.size() == 0) begin
         report_error("result with nothing pending");
         return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r.saturated)
         sat_count++;
      if (exp_r.max_ratio == 0)
         zero_count++;
      if (ratio !== exp_r.max_ratio)
         report_error($sformatf("max_ratio got %h want %h", ratio, exp_r.max_ratio));
      if (sat !== exp_r.saturated)
         report_error($sformatf("saturated got %b want %b", sat, exp_r.saturated));
   endtask

   task report_error(string msg);
      error_count++;
      $display("mismatch %0d at %0t: %s", error_count, $realtime, msg);
   endtask
endclass

module tb_cell_edge_aspect_ratio_top;
   import cear_pkg::*;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   sent_count;

   cear_req_if req_ch ();
   cear_rsp_if rsp_ch ();
   ratio_scoreboard ratio_sb;

   cell_edge_aspect_ratio_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // initial values
   initial begin
      ratio_sb          = new();
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.base_x     = '0;
      req_ch.base_y     = '0;
      req_ch.base_z     = '0;
      req_ch.inext_x    = '0;
      req_ch.inext_y    = '0;
      req_ch.inext_z    = '0;
      req_ch.jnext_x    = '0;
      req_ch.jnext_y    = '0;
      req_ch.jnext_z    = '0;
      req_ch.knext_x    = '0;
      req_ch.knext_y    = '0;
      req_ch.knext_z    = '0;
      rsp_ch.ready      = 1'b0;
      send_idle_pct     = 0;
      recv_idle_pct     = 0;
      sent_count        = 0;
   end

   // receiver ready with random stalls
   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         ratio_sb.check_result(rsp_ch.max_ratio, rsp_ch.saturated);
   end

   // drive one cell and wait for its transfer; valid is left for the next caller
   task automatic send_cell(logic signed [23:0] pt[4][3]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.base_x  <= pt[0][0];
      req_ch.base_y  <= pt[0][1];
      req_ch.base_z  <= pt[0][2];
      req_ch.inext_x <= pt[1][0];
      req_ch.inext_y <= pt[1][1];
      req_ch.inext_z <= pt[1][2];
      req_ch.jnext_x <= pt[2][0];
      req_ch.jnext_y <= pt[2][1];
      req_ch.jnext_z <= pt[2][2];
      req_ch.knext_x <= pt[3][0];
      req_ch.knext_y <= pt[3][1];
      req_ch.knext_z <= pt[3][2];
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      ratio_sb.note_cell(pt);
      sent_count++;
      @(negedge clock);
   endtask

   // random cell: offsets of mixed scale around a random corner, or fully random points
   task automatic send_random_cell();
      logic signed [23:0] pt[4][3];
      int mode;
      int span;
      mode = $urandom_range(9);
      for (int c = 0; c < 3; c++)
         pt[0][c] = 24'($urandom);
      for (int p = 1; p < 4; p++) begin
         span = (mode == 0) ? 24 : $urandom_range(20);
         for (int c = 0; c < 3; c++) begin
            if (mode == 0)
               pt[p][c] = 24'($urandom);
            else if (mode == 1 && p == 3 && $urandom_range(1))
               pt[p][c] = pt[0][c];
            else
               pt[p][c] = pt[0][c] + 24'($signed($urandom_range((1 << span) - 1))
                          - (1 << (span - 1)));
         end
      end
      send_cell(pt);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (ratio_sb.pending_q.size() != 0)
         @(negedge clock);
   endtask

   // fill a cell from corner and the i, j and k edge offsets
   task automatic send_edges(logic signed [23:0] b[3], logic signed [23:0] ei[3],
                             logic signed [23:0] ej[3], logic signed [23:0] ek[3]);
      logic signed [23:0] pt[4][3];
      for (int c = 0; c < 3; c++) begin
         pt[0][c] = b[c];
         pt[1][c] = b[c] + ei[c];
         pt[2][c] = b[c] + ej[c];
         pt[3][c] = b[c] + ek[c];
      end
      send_cell(pt);
   endtask

   // stimulus
   initial begin
      logic signed [23:0] pt[4][3];
      logic signed [23:0] mn;
      logic signed [23:0] mx;
      mn = 24'sh800000;
      mx = 24'sh7FFFFF;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // degenerate cell: all points equal
      send_edges('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
      send_edges('{mx, mx, mx}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
      // unit cube
      send_edges('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1});
      // one zero-length edge
      send_edges('{5, -5, 7}, '{3, 4, 0}, '{0, 0, 0}, '{0, -2, 1});
      // two zero-length edges
      send_edges('{-9, 2, 1}, '{0, 0, 0}, '{0, 0, 0}, '{100, 0, 0});
      // extreme spread: full-range diagonal
      for (int c = 0; c < 3; c++) begin
         pt[0][c] = mn;
         pt[1][c] = mx;
         pt[2][c] = mn;
         pt[3][c] = mx;
      end
      pt[2][0] = mn + 1;
      send_cell(pt);
      // saturation: length ratio beyond 65535
      send_edges('{0, 0, 0}, '{24'sh7FFFFF, 0, 0}, '{1, 0, 0}, '{0, 1, 0});
      send_edges('{mn, mn, mn}, '{0, 0, 0}, '{0, 0, 1}, '{24'sh100000, 0, 0});
      // ratio near the saturation boundary
      send_edges('{0, 0, 0}, '{65535, 0, 0}, '{1, 0, 0}, '{0, 0, 1});
      send_edges('{0, 0, 0}, '{65536, 0, 0}, '{1, 0, 0}, '{0, 0, 1});
      send_edges('{0, 0, 0}, '{-65536, 0, 0}, '{0, -1, 0}, '{0, 0, 65535});
      // opposite corners of the coordinate range
      for (int c = 0; c < 3; c++) begin
         pt[0][c] = mx;
         pt[1][c] = mn;
         pt[2][c] = (c == 0) ? mn : mx;
         pt[3][c] = 24'sh0;
      end
      send_cell(pt);
      for (int c = 0; c < 3; c++) begin
         pt[0][c] = mn;
         pt[1][c] = mx;
         pt[2][c] = (c == 1) ? mx : mn;
         pt[3][c] = 24'sh555555;
         pt[3][c] = pt[3][c] ^ {24{c[0]}};
      end
      send_cell(pt);
      // equal edges with irrational lengths
      send_edges('{1, 2, 3}, '{1, 1, 0}, '{0, 1, 1}, '{1, 0, 1});
      send_edges('{0, 0, 0}, '{3, 5, 7}, '{-7, 3, -5}, '{5, -7, 3});

      // pause until everything has drained
      wait_drained();

      // random phases with different idling
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 79 : 0;
         recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 17 : 0;
         repeat (500) send_random_cell();
      end

      wait_drained();
      repeat (120) @(negedge clock);
      $display("covered %0d cells, %0d results checked, %0d saturated, %0d zero ratios",
               sent_count, ratio_sb.checked_count, ratio_sb.sat_count,
               ratio_sb.zero_count);
      if (ratio_sb.error_count == 0 && ratio_sb.pending_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("timeout with %0d results pending", ratio_sb.pending_q.size());
      $display("FAIL");
      $finish;
   end

endmodule
